>>> design/image_rotate_quarter_turn_defines.svh
// assertion macros used by the back end of the image rotate block
`ifndef IMAGE_ROTATE_QUARTER_TURN_DEFINES_SVH
`define IMAGE_ROTATE_QUARTER_TURN_DEFINES_SVH
`ifndef SYNTHESIS
`define IRQT_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("%m: assertion failed");
`define IRQT_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("%m: assertion failed");
`else
`define IRQT_ASSERT(lbl, expr)
`define IRQT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> design/irqt_pkg.sv
// types and constants of the image rotate block
`timescale 1ns / 1ps
package irqt_pkg;
	localparam int SAMPLE_W    = 8;
	localparam int SIZE_W      = 7;
	localparam int CFG_INDEX_W = 2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam logic DIR_CW  = 1'b0;
	localparam logic DIR_CCW = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WIDTH     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT    = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	typedef struct packed {
		logic                cmd;
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
	} pixel_in_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] out_red;
		logic [SAMPLE_W-1:0] out_green;
		logic [SAMPLE_W-1:0] out_blue;
		logic                last_pixel;
	} pixel_out_t;

	// one classified operation handed from front to back
	typedef struct packed {
		logic                drain;
		logic                last;
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
	} op_t;
endpackage

>>> design/irqt_front.sv
// front end: config registers, raster counters and address generation
`timescale 1ns / 1ps
module irqt_front #(
	parameter int MAX_WIDTH   = 64,
	parameter int MAX_HEIGHT  = 64,
	parameter int SAMPLE_BITS = 8,
	parameter int AW          = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                src_valid,
	output logic                                src_stall,
	input  irqt_pkg::pixel_in_t                 src_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [irqt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [irqt_pkg::SIZE_W-1:0]         cfg_data,
	input  logic                                full,
	output logic                                push,
	output irqt_pkg::op_t                       push_op,
	output logic [AW-1:0]                       push_addr
);
	import irqt_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int KW0 = (CW > RW) ? CW : RW;
	localparam int KW  = ((KW0 > SIZE_W) ? KW0 : SIZE_W) + 1;
	localparam int SB  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SB) - 1);

	logic              dir_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [CW-1:0]     load_col_q;
	logic [RW-1:0]     load_row_q;
	logic [CW-1:0]     drain_row_q;
	logic [RW-1:0]     drain_col_q;

	logic [SIZE_W-1:0] w;
	logic [SIZE_W-1:0] h;
	logic [KW-1:0]     w_k, h_k;
	logic [KW-1:0]     lcol, lrow, drow, dcol;
	logic [KW-1:0]     lcol_inc, lrow_inc, drow_inc, dcol_inc;
	logic [KW-1:0]     row_k, col_k;
	logic              accept;
	logic              is_drain;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input int maxv);
		if (v == '0)
			return SIZE_W'(1);
		else if (int'(v) > maxv)
			return SIZE_W'(maxv);
		else
			return v;
	endfunction

	always_comb begin
		w   = clamp_size(width_q, MAX_WIDTH);
		h   = clamp_size(height_q, MAX_HEIGHT);
		w_k = KW'(w);
		h_k = KW'(h);
		// a counter left beyond a shrunken bound restarts at zero
		lcol = (KW'(load_col_q) >= w_k) ? '0 : KW'(load_col_q);
		lrow = (KW'(load_row_q) >= h_k) ? '0 : KW'(load_row_q);
		drow = (KW'(drain_row_q) >= w_k) ? '0 : KW'(drain_row_q);
		dcol = (KW'(drain_col_q) >= h_k) ? '0 : KW'(drain_col_q);
		lcol_inc = lcol + KW'(1);
		lrow_inc = lrow + KW'(1);
		drow_inc = drow + KW'(1);
		dcol_inc = dcol + KW'(1);
		is_drain = (src_data.cmd == CMD_DRAIN);
		if (!is_drain) begin
			row_k = lrow;
			col_k = lcol;
		end else if (dir_q == DIR_CW) begin
			row_k = h_k - KW'(1) - dcol;
			col_k = drow;
		end else begin
			row_k = dcol;
			col_k = w_k - KW'(1) - drow;
		end
	end

	assign accept    = src_valid && !full;
	assign src_stall = full;
	assign cfg_ready = 1'b1;
	assign push      = accept;
	assign push_addr = AW'(row_k) * AW'(MAX_WIDTH) + AW'(col_k);

	always_comb begin
		push_op.drain = is_drain;
		push_op.last  = is_drain && (drow == w_k - KW'(1)) && (dcol == h_k - KW'(1));
		push_op.red   = src_data.red & SAMPLE_MASK;
		push_op.green = src_data.green & SAMPLE_MASK;
		push_op.blue  = src_data.blue & SAMPLE_MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= DIR_CW;
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DIRECTION: dir_q <= cfg_data[0];
				REG_WIDTH:     width_q <= cfg_data;
				REG_HEIGHT:    height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_col_q  <= '0;
			load_row_q  <= '0;
			drain_row_q <= '0;
			drain_col_q <= '0;
		end else if (accept) begin
			if (!is_drain) begin
				if (lcol_inc >= w_k) begin
					load_col_q <= '0;
					load_row_q <= (lrow_inc >= h_k) ? '0 : RW'(lrow_inc);
				end else begin
					load_col_q <= CW'(lcol_inc);
					load_row_q <= RW'(lrow);
				end
			end else begin
				if (dcol_inc >= h_k) begin
					drain_col_q <= '0;
					drain_row_q <= (drow_inc >= w_k) ? '0 : CW'(drow_inc);
				end else begin
					drain_col_q <= RW'(dcol_inc);
					drain_row_q <= CW'(drow);
				end
			end
		end
	end
endmodule

>>> design/irqt_queue.sv
// two-entry queue between front and back
`timescale 1ns / 1ps
module irqt_queue #(
	parameter int WIDTH = 38
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);
	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full      = (count_q == NW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + NW'(1);
			else if (pop && !push)
				count_q <= count_q - NW'(1);
		end
	end
endmodule

>>> design/irqt_back.sv
// back end: frame store and registered result
`timescale 1ns / 1ps
`include "image_rotate_quarter_turn_defines.svh"
module irqt_back #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int AW         = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  irqt_pkg::op_t        q_op,
	input  logic [AW-1:0]        q_addr,
	output logic                 pop,
	output logic                 dst_valid,
	input  logic                 dst_stall,
	output irqt_pkg::pixel_out_t dst_data
);
	import irqt_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int PIX_W = 3 * SAMPLE_W;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_q;
	logic             last_q;
	logic             out_valid_q;
	logic             wr_en;
	logic             rd_en;

	// a drain goes only when the result register is free or being taken
	assign pop   = q_valid && (!q_op.drain || !out_valid_q || !dst_stall);
	assign wr_en = pop && !q_op.drain;
	assign rd_en = pop && q_op.drain;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[q_addr] <= {q_op.red, q_op.green, q_op.blue};
		if (rd_en) begin
			rd_q   <= mem[q_addr];
			last_q <= q_op.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (rd_en)
			out_valid_q <= 1'b1;
		else if (!dst_stall)
			out_valid_q <= 1'b0;
	end

	assign dst_valid           = out_valid_q;
	assign dst_data.out_red    = rd_q[PIX_W-1 -: SAMPLE_W];
	assign dst_data.out_green  = rd_q[2*SAMPLE_W-1 -: SAMPLE_W];
	assign dst_data.out_blue   = rd_q[SAMPLE_W-1:0];
	assign dst_data.last_pixel = last_q;

	`IRQT_ASSERT_NEXT(a_read_gives_result, rd_en, out_valid_q)
	`IRQT_ASSERT(a_no_read_over_stalled, !(rd_en && out_valid_q && dst_stall))
	`IRQT_ASSERT_NEXT(a_stalled_result_holds, out_valid_q && dst_stall,
		out_valid_q && $stable(rd_q) && $stable(last_q))
endmodule

>>> design/image_rotate_quarter_turn.sv
// top level of the quarter-turn image rotator
// a drain transaction passes the queue, then the registered frame store read, before its pixel shows
// throughput: one transaction per cycle, load or drain, while the output is not stalled
// a load takes one frame store write; a drain one registered frame store read
// reset: size registers to 64, direction clockwise, load and drain counters to zero
// reset: the frame store is not cleared; entries read before they are loaded are undefined
`timescale 1ns / 1ps
module image_rotate_quarter_turn #(
	parameter int MAX_WIDTH   = 64,
	parameter int MAX_HEIGHT  = 64,
	parameter int SAMPLE_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// source channel: load and drain transactions
	input  logic                             src_valid,
	output logic                             src_stall,
	input  irqt_pkg::pixel_in_t              src_data,
	// result channel: one rotated pixel per drain
	output logic                             dst_valid,
	input  logic                             dst_stall,
	output irqt_pkg::pixel_out_t             dst_data,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [irqt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [irqt_pkg::SIZE_W-1:0]      cfg_data
);
	import irqt_pkg::*;

	// address of one pixel in the frame store, row major at the maximum width
	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
	// queue entry: store address above the classified operation
	localparam int QW = AW + $bits(op_t);

	logic          push;
	op_t           push_op;
	logic [AW-1:0] push_addr;
	logic          full;
	logic          pop;
	logic          pop_valid;
	logic [QW-1:0] pop_data;
	op_t           q_op;
	logic [AW-1:0] q_addr;

	// front: holds the registers, walks the load and drain rasters,
	// turns each transaction into a store address plus an operation
	irqt_front #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.SAMPLE_BITS (SAMPLE_BITS),
		.AW          (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.full      (full),
		.push      (push),
		.push_op   (push_op),
		.push_addr (push_addr)
	);

	// short queue so that a stalled output does not stall the source at once
	irqt_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_addr, push_op}),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	assign q_addr = pop_data[QW-1 -: AW];
	assign q_op   = pop_data[$bits(op_t)-1:0];

	// back: writes loads into the store, reads drains into the result register
	irqt_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.AW         (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_op      (q_op),
		.q_addr    (q_addr),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);
endmodule

>>> bench/image_rotate_quarter_turn_test.sv
// self-checking bench for the quarter-turn image rotator: directed frames, then random frames
`timescale 1ns / 1ps
module image_rotate_quarter_turn_test;
	import irqt_pkg::*;

	// block sizes as built, and the run pacing knobs
	localparam int FRAME_W_MAX  = 64;
	localparam int FRAME_H_MAX  = 64;
	localparam int STORE_DEPTH  = FRAME_W_MAX * FRAME_H_MAX;
	localparam int RANDOM_ITEMS = 500;
	// random transactions at the end with no idling, above the longest frame of 192
	localparam int QUIET_ITEMS  = 200;
	localparam int SETTLE_TAIL  = 8;       // cycles past the last result
	localparam int LONG_HOLD    = 150;     // receiver hold-off that backs up the block
	localparam int RUN_LIMIT    = 200000;

	// clock, reset and block ports; the ones driven here are known from time zero
	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       src_valid = 1'b0;
	logic       src_stall;
	pixel_in_t  src_data  = '0;
	logic       dst_valid;
	logic       dst_stall = 1'b0;
	pixel_out_t dst_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0]      cfg_data  = '0;

	// shared run state
	bit pace_on       = 1'b1;          // random idling on both channels
	int sink_hold_len = 0;             // nonzero asks the receiver for one long hold-off
	int items_sent    = 0;
	int mismatch_count = 0;
	int cycle_count   = 0;

	// own copy of the rotator: frame store, registers and raster counters
	logic [3*SAMPLE_W-1:0] frame_copy [STORE_DEPTH];
	bit                    was_loaded [STORE_DEPTH];
	logic                  turn_dir   = DIR_CW;
	logic [SIZE_W-1:0]     width_reg  = SIZE_RESET;
	logic [SIZE_W-1:0]     height_reg = SIZE_RESET;
	int load_row  = 0;
	int load_col  = 0;
	int drain_row = 0;
	int drain_col = 0;

	// rotated pixels still owed by the block, oldest first
	pixel_out_t rotated_pixels_due [$];

	image_rotate_quarter_turn #(
		.MAX_WIDTH  (FRAME_W_MAX),
		.MAX_HEIGHT (FRAME_H_MAX),
		.SAMPLE_BITS(SAMPLE_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_data (dst_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin : clock_gen
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin : watchdog
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > RUN_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// a size register of zero acts as one, anything past the maximum acts as the maximum
	function automatic int eff_size(input logic [SIZE_W-1:0] v, input int limit);
		if (v == '0)
			return 1;
		if (int'(v) > limit)
			return limit;
		return int'(v);
	endfunction

	// store entry the next drain reads, after counters past a shrunk size restart
	function automatic int drain_source_addr();
		int w, h, r, c;
		w = eff_size(width_reg, FRAME_W_MAX);
		h = eff_size(height_reg, FRAME_H_MAX);
		r = (drain_row >= w) ? 0 : drain_row;
		c = (drain_col >= h) ? 0 : drain_col;
		// clockwise: source row h-1-c, column r; counterclockwise: row c, column w-1-r
		if (turn_dir == DIR_CW)
			return (h - 1 - c) * FRAME_W_MAX + r;
		return c * FRAME_W_MAX + (w - 1 - r);
	endfunction

	// advance the copy by one accepted transaction, queue the pixel a drain must return
	task automatic track_rotation(input pixel_in_t px);
		int w, h, a;
		pixel_out_t rot;
		w = eff_size(width_reg, FRAME_W_MAX);
		h = eff_size(height_reg, FRAME_H_MAX);
		if (px.cmd == CMD_LOAD) begin
			if (load_col >= w)
				load_col = 0;
			if (load_row >= h)
				load_row = 0;
			a = load_row * FRAME_W_MAX + load_col;
			frame_copy[a] = {px.red, px.green, px.blue};
			was_loaded[a] = 1'b1;
			load_col++;
			if (load_col >= w) begin
				load_col = 0;
				load_row++;
				if (load_row >= h)
					load_row = 0;
			end
		end else begin
			a = drain_source_addr();
			if (drain_row >= w)
				drain_row = 0;
			if (drain_col >= h)
				drain_col = 0;
			{rot.out_red, rot.out_green, rot.out_blue} = frame_copy[a];
			rot.last_pixel = (drain_row == w - 1) && (drain_col == h - 1);
			rotated_pixels_due.push_back(rot);
			// rotated raster: columns of the rotated frame run fastest
			drain_col++;
			if (drain_col >= h) begin
				drain_col = 0;
				drain_row++;
				if (drain_row >= w)
					drain_row = 0;
			end
		end
	endtask

	function automatic pixel_in_t load_px(input logic [SAMPLE_W-1:0] r,
			input logic [SAMPLE_W-1:0] g, input logic [SAMPLE_W-1:0] b);
		pixel_in_t px;
		px.cmd   = CMD_LOAD;
		px.red   = r;
		px.green = g;
		px.blue  = b;
		return px;
	endfunction

	// drains carry random samples too, the block must ignore them
	function automatic pixel_in_t random_pixel(input logic cmd);
		pixel_in_t px;
		px.cmd   = cmd;
		px.red   = SAMPLE_W'($urandom_range(0, 255));
		px.green = SAMPLE_W'($urandom_range(0, 255));
		px.blue  = SAMPLE_W'($urandom_range(0, 255));
		return px;
	endfunction

	// one source transaction: optional idle burst, then hold until accepted
	task automatic send_pixel(input pixel_in_t px);
		pixel_in_t item;
		item = px;
		// a drain that would hit a never loaded entry becomes a load instead
		if (item.cmd == CMD_DRAIN && !was_loaded[drain_source_addr()])
			item.cmd = CMD_LOAD;
		if (pace_on && $urandom_range(0, 3) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data  <= item;
		do @(posedge clk); while (src_stall);
		track_rotation(item);
		items_sent++;
	endtask

	task automatic load_frame(input int count);
		repeat (count) send_pixel(random_pixel(CMD_LOAD));
	endtask

	task automatic drain_frame(input int count);
		repeat (count) send_pixel(random_pixel(CMD_DRAIN));
	endtask

	// random mix of loads and drains, drain_pct in percent
	task automatic mixed_burst(input int count, input int drain_pct);
		repeat (count)
			send_pixel(random_pixel(($urandom_range(0, 99) < drain_pct) ? CMD_DRAIN : CMD_LOAD));
	endtask

	// stop sending, wait for every owed pixel, then let the pipe run empty
	task automatic wait_results_done();
		src_valid <= 1'b0;
		while (rotated_pixels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TAIL) @(posedge clk);
	endtask

	// one register write transaction, cfg_valid is handled by the caller
	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DIRECTION: turn_dir = val[0];
			REG_WIDTH: width_reg = val;
			REG_HEIGHT: height_reg = val;
			default: ;
		endcase
	endtask

	// only called with the block idle
	task automatic set_registers(input logic dir, input logic [SIZE_W-1:0] wv,
			input logic [SIZE_W-1:0] hv);
		cfg_valid <= 1'b1;
		cfg_write(REG_DIRECTION, SIZE_W'(dir));
		cfg_write(REG_WIDTH, wv);
		cfg_write(REG_HEIGHT, hv);
		cfg_valid <= 1'b0;
	endtask

	// receiver pacing: random stall bursts, or one long hold-off on request
	initial begin : sink_pacing
		forever begin
			@(posedge clk);
			if (sink_hold_len > 0) begin
				dst_stall <= 1'b1;
				repeat (sink_hold_len) @(posedge clk);
				sink_hold_len = 0;
				dst_stall <= 1'b0;
			end else if (pace_on && $urandom_range(0, 3) == 0) begin
				dst_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				dst_stall <= 1'b0;
			end
		end
	end

	// every accepted result transaction against the oldest owed pixel
	initial begin : result_check
		pixel_out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && dst_valid && !dst_stall) begin
				if (rotated_pixels_due.size() == 0) begin
					$error("rotated pixel with none owed: %h", dst_data);
					mismatch_count++;
				end else begin
					want = rotated_pixels_due.pop_front();
					if (dst_data.out_red !== want.out_red) begin
						$error("out_red: expected %0d, got %0d", want.out_red, dst_data.out_red);
						mismatch_count++;
					end
					if (dst_data.out_green !== want.out_green) begin
						$error("out_green: expected %0d, got %0d", want.out_green,
							dst_data.out_green);
						mismatch_count++;
					end
					if (dst_data.out_blue !== want.out_blue) begin
						$error("out_blue: expected %0d, got %0d", want.out_blue,
							dst_data.out_blue);
						mismatch_count++;
					end
					if (dst_data.last_pixel !== want.last_pixel) begin
						$error("last_pixel: expected %0d, got %0d", want.last_pixel,
							dst_data.last_pixel);
						mismatch_count++;
					end
				end
			end
		end
	end

	// loads under the reset sizes, sample extremes
	task automatic test_loads_at_reset();
		send_pixel(load_px(8'h00, 8'h00, 8'h00));
		send_pixel(load_px(8'hFF, 8'hFF, 8'hFF));
		send_pixel(load_px(8'hA5, 8'h5A, 8'h3C));
	endtask

	// shrinking sizes with counters past the new bound restarts them
	task automatic test_shrink_restarts_counters();
		wait_results_done();
		// load column three lies past a width of two
		set_registers(DIR_CW, 7'd2, 7'd2);
		send_pixel(load_px(8'h01, 8'hFE, 8'h80));
		send_pixel(load_px(8'h7F, 8'h10, 8'hEF));
		send_pixel(load_px(8'hC0, 8'h03, 8'h55));
		send_pixel(load_px(8'h2A, 8'hD5, 8'h00));
		drain_frame(3);
		// drain column one lies past a height of one
		wait_results_done();
		set_registers(DIR_CW, 7'd2, 7'd1);
		drain_frame(1);
	endtask

	// counterclockwise on a non-square frame, every channel at both extremes
	task automatic test_counterclockwise();
		wait_results_done();
		set_registers(DIR_CCW, 7'd3, 7'd2);
		send_pixel(load_px(8'hFF, 8'h00, 8'h00));
		send_pixel(load_px(8'h00, 8'hFF, 8'h00));
		send_pixel(load_px(8'h00, 8'h00, 8'hFF));
		send_pixel(load_px(8'hFF, 8'hFF, 8'h00));
		send_pixel(load_px(8'h00, 8'hFF, 8'hFF));
		send_pixel(load_px(8'hFF, 8'h00, 8'hFF));
		drain_frame(6);
	endtask

	// sizes of zero and past the maximum, drained before the frame is fully loaded
	task automatic test_size_clamp();
		wait_results_done();
		set_registers(DIR_CCW, 7'd0, 7'd127);
		drain_frame(2);
		wait_results_done();
		set_registers(DIR_CW, 7'd127, 7'd0);
		drain_frame(3);
	endtask

	// receiver holds off long enough for the block to stall its input
	task automatic test_output_backpressure();
		wait_results_done();
		set_registers(DIR_CW, 7'd4, 7'd4);
		load_frame(16);
		sink_hold_len = LONG_HOLD;
		drain_frame(16);
	endtask

	// sender goes quiet mid-frame until every owed pixel is out
	task automatic test_sender_pause();
		drain_frame(5);
		wait_results_done();
		drain_frame(11);
	endtask

	// random frames: mostly full load then full drain, some interleaved, some noise
	task automatic test_random_frames();
		int stop_at, phase, n, kind;
		logic dir;
		logic [SIZE_W-1:0] wv, hv;
		stop_at = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < stop_at) begin
			wait_results_done();
			// first frames take the size corners, the rest stay small
			case (phase)
				0: begin dir = DIR_CW;  wv = 7'd64;  hv = 7'd1;   end
				1: begin dir = DIR_CCW; wv = 7'd1;   hv = 7'd64;  end
				2: begin dir = DIR_CCW; wv = 7'd127; hv = 7'd0;   end
				default: begin
					dir = logic'($urandom_range(0, 1));
					wv  = SIZE_W'($urandom_range(0, 8));
					hv  = SIZE_W'($urandom_range(0, 8));
				end
			endcase
			set_registers(dir, wv, hv);
			n = eff_size(wv, FRAME_W_MAX) * eff_size(hv, FRAME_H_MAX);
			// some frames run with no idling, and the tail of the run has none
			if (items_sent > stop_at - QUIET_ITEMS)
				pace_on = 1'b0;
			else
				pace_on = ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				load_frame(n);
				drain_frame(n);
			end else if (kind < 9) begin
				load_frame(n);
				mixed_burst(2 * n, 60);
			end else begin
				mixed_burst(n, 50);
			end
			phase++;
		end
	endtask

	initial begin : run_tests
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_loads_at_reset();
		test_shrink_restarts_counters();
		test_counterclockwise();
		test_size_clamp();
		test_output_backpressure();
		test_sender_pause();
		test_random_frames();
		pace_on = 1'b0;
		wait_results_done();
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

>>> files.f
+incdir+design
design/irqt_pkg.sv
design/irqt_front.sv
design/irqt_queue.sv
design/irqt_back.sv
design/image_rotate_quarter_turn.sv
bench/image_rotate_quarter_turn_test.sv
